@@ hdl/bps_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, codes and pattern tables for the beep pattern sequencer.
// ----------------------------------------------------------------------------
package bps_pkg;

  // operation codes carried in s_axis_tuser
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  localparam int TABLE_STEPS = 9;
  localparam int OFFSET_W    = 11;
  localparam int FREQ_W      = 16;
  localparam int TIME_W      = 32;

  // pattern order: happy, short single, long single, sad
  localparam logic [3:0] PAT_LEN [4] = '{4'd9, 4'd3, 4'd3, 4'd9};

  localparam logic [OFFSET_W-1:0] OFFSET_TAB [4][TABLE_STEPS] = '{
    '{11'd0, 11'd270, 11'd300, 11'd370, 11'd400, 11'd570, 11'd600, 11'd900, 11'd1200},
    '{11'd0, 11'd250, 11'd500, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
    '{11'd0, 11'd750, 11'd1000, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0, 11'd0},
    '{11'd0, 11'd100, 11'd200, 11'd300, 11'd400, 11'd500, 11'd600, 11'd1200, 11'd1500}
  };

  localparam logic [FREQ_W-1:0] FREQ_TAB [4][TABLE_STEPS] = '{
    '{16'd2000, 16'd0, 16'd2300, 16'd0, 16'd2600, 16'd0, 16'd2900, 16'd0, 16'd0},
    '{16'd2600, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd2600, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0},
    '{16'd2900, 16'd0, 16'd2600, 16'd0, 16'd2300, 16'd0, 16'd2000, 16'd0, 16'd0}
  };

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic start;  // latch start time and pattern, clear fired marks
    logic load;   // latch elapsed time, rewind step index
    logic step;   // evaluate current step and advance
    logic flush;  // move held result to output as last of run
  } bps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic playing;
    logic hit;
    logic is_final;
    logic hold_valid;
    logic out_free;
  } bps_status_t;

  function automatic logic [OFFSET_W-1:0] step_offset(logic [1:0] pat, logic [3:0] idx);
    if (idx < 4'(TABLE_STEPS)) return OFFSET_TAB[pat][idx];
    return '0;
  endfunction

  function automatic logic [FREQ_W-1:0] step_freq(logic [1:0] pat, logic [3:0] idx);
    if (idx < 4'(TABLE_STEPS)) return FREQ_TAB[pat][idx];
    return '0;
  endfunction

endpackage

@@ hdl/bps_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_datapath
// Sequencer state, step evaluation, held result and output register.
// ----------------------------------------------------------------------------
module bps_datapath #(
  parameter int MAX_STEPS = 9
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic                        cfg_tone_mode,
  input  logic [1:0]                  pattern,
  input  logic [bps_pkg::TIME_W-1:0]  time_ms,
  input  bps_pkg::bps_cmd_t           cmd,
  output bps_pkg::bps_status_t        status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bps_pkg::FREQ_W-1:0]  out_drive,
  output logic                        out_done,
  output logic                        out_last
);
  import bps_pkg::*;

  localparam int IW = $clog2(MAX_STEPS);

  logic                 tone_mode;
  logic                 playing;
  logic [TIME_W-1:0]    start_time;
  logic [1:0]           active_pattern;
  logic [MAX_STEPS-1:0] fired;
  logic [TIME_W-1:0]    elapsed;
  logic [IW-1:0]        idx;
  logic                 hold_valid;
  logic [FREQ_W-1:0]    hold_drive;
  logic                 hold_done;

  logic [4:0]           eff_len;
  logic [IW-1:0]        last_idx;
  logic [FREQ_W-1:0]    freq;
  logic [FREQ_W-1:0]    drive;
  logic                 hit;
  logic                 is_final;
  logic                 out_free;

  // pattern length clipped to the step capacity
  always_comb begin
    if (5'(PAT_LEN[active_pattern]) > 5'(MAX_STEPS)) eff_len = 5'(MAX_STEPS);
    else eff_len = 5'(PAT_LEN[active_pattern]);
  end

  assign last_idx = IW'(eff_len - 5'd1);
  assign freq     = step_freq(active_pattern, 4'(idx));
  assign drive    = tone_mode ? freq : {{(FREQ_W-1){1'b0}}, (freq != '0)};
  assign hit      = (elapsed > TIME_W'(step_offset(active_pattern, 4'(idx)))) && !fired[idx];
  assign is_final = (idx == last_idx);
  assign out_free = !out_valid || out_ready;

  assign status = '{playing: playing, hit: hit, is_final: is_final,
                    hold_valid: hold_valid, out_free: out_free};

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      tone_mode      <= 1'b1;
      playing        <= 1'b0;
      start_time     <= '0;
      active_pattern <= '0;
      fired          <= '0;
      hold_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) tone_mode <= cfg_tone_mode;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.start) begin
        start_time     <= time_ms;
        playing        <= 1'b1;
        active_pattern <= pattern;
        fired          <= '0;
      end
      if (cmd.load) hold_valid <= 1'b0;
      if (cmd.step && hit) begin
        fired[idx] <= 1'b1;
        hold_valid <= 1'b1;
        if (hold_valid) out_valid <= 1'b1;
        if (is_final) playing <= 1'b0;
      end
      if (cmd.flush) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      elapsed <= time_ms - start_time;
      idx     <= '0;
    end
    if (cmd.step) begin
      idx <= idx + 1'b1;
      if (hit) begin
        hold_drive <= drive;
        hold_done  <= is_final;
        if (hold_valid) begin
          out_drive <= hold_drive;
          out_done  <= hold_done;
          out_last  <= 1'b0;
        end
      end
    end
    if (cmd.flush) begin
      out_drive <= hold_drive;
      out_done  <= hold_done;
      out_last  <= 1'b1;
    end
  end

endmodule

@@ hdl/bps_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_ctrl
// Controller: accepts items, walks the steps of a tick, flushes the run.
// ----------------------------------------------------------------------------
module bps_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_op,
  output logic                 in_ready,
  input  bps_pkg::bps_status_t status,
  output bps_pkg::bps_cmd_t    cmd
);
  import bps_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_START) begin
            cmd.start = !status.playing;
          end else if (status.playing) begin
            cmd.load   = 1'b1;
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // a new hit pushes the held result out, so it needs a free slot
        if (!(status.hit && status.hold_valid && !status.out_free)) begin
          cmd.step = 1'b1;
          if (status.is_final) state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (!status.hold_valid) begin
          state_next = S_IDLE;
        end else if (status.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ hdl/beep_pattern_sequencer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beep_pattern_sequencer
// Buzzer tone sequencer playing one of four fixed beep patterns.
// ----------------------------------------------------------------------------
// A start transfer (tuser = 1) picks pattern tdata[1:0] and latches time
// tdata[33:2] as the start time; it is dropped while a pattern still plays.
// A tick transfer (tuser = 0) carries the current millisecond time. Every
// step not yet fired whose offset is strictly below the elapsed time fires
// in step order and produces one output transfer: drive value in tdata
// (frequency in Hz, or 0/1 pin level when tone_mode is 0), tuser set on the
// pattern's final step, tlast on the last transfer of that tick. A start or
// an idle tick is handled in IDLE alone; a tick while playing goes from IDLE
// through SCAN, which walks the pattern's steps in order, to FLUSH, and the
// step walker evaluates one table step per cycle; output backpressure stalls
// it only when a second result is ready before the first is taken.
// The last result sits in the output register, so the next input transfer
// can be taken while it waits. tone_mode is written on the cfg channel
// (always ready) and should only change while the block is idle.
// ----------------------------------------------------------------------------
module beep_pattern_sequencer #(
  parameter int MAX_STEPS = 9
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: tone_mode
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [1:0] pattern, [33:2] time_ms, [39:34] zero
  input  logic        s_axis_tuser,   // [0] operation
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [15:0] drive_value
  output logic        m_axis_tuser,   // [0] sequence_done
  output logic        m_axis_tlast    // last_of_run
);
  import bps_pkg::*;

  bps_cmd_t    cmd;
  bps_status_t status;

  assign cfg_ready = 1'b1;

  bps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bps_datapath #(
    .MAX_STEPS (MAX_STEPS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_tone_mode (cfg_data),
    .pattern       (s_axis_tdata[1:0]),
    .time_ms       (s_axis_tdata[33:2]),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (m_axis_tvalid),
    .out_ready     (m_axis_tready),
    .out_drive     (m_axis_tdata),
    .out_done      (m_axis_tuser),
    .out_last      (m_axis_tlast)
  );

endmodule

@@ hdl/bps_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bps_checker
// Port-level checks for the beep pattern sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module bps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // final step of a pattern always closes the run
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("sequence_done without tlast");

  // input is ready again in the cycle after a start transfer
  a_start_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready)
    else $error("not ready after start transfer");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind beep_pattern_sequencer bps_checker u_bps_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
